[src/bird_pkg.sv]
// ----------------------------------------------------------------------------
// bird_pkg: shared types and constants of the bit image run decoder
// Field widths, stream byte codes, register indexes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bird_pkg;

    localparam int CODE_W      = 8;
    localparam int CHUNK_W     = 64;
    localparam int COUNT_W     = 4;
    localparam int REPEAT_W    = 8;
    localparam int LINE_CFG_W  = 9;
    localparam int PLEN_W      = 2;
    localparam int TOTAL_W     = 9;
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = $clog2(MAX_RESULTS);
    localparam int CFG_INDEX_W = 1;

    localparam logic [CODE_W-1:0] BYTE_ZERO    = 8'h00;
    localparam logic [CODE_W-1:0] BYTE_LITERAL = 8'h80;
    localparam logic [CODE_W-1:0] MASK_COUNT   = 8'h7f;
    localparam logic [CODE_W-1:0] SOLID_ONES   = 8'hff;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BYTES     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

    localparam logic [LINE_CFG_W-1:0] LINE_BYTES_RESET     = 9'd80;
    localparam logic [PLEN_W-1:0]     PATTERN_LENGTH_RESET = 2'd2;

    typedef enum logic [3:0] {
        ST_OPCODE,
        ST_AFTER_ZERO,
        ST_PATTERN,
        ST_SL_FLAG,
        ST_SL_COUNT,
        ST_LIT_COUNT,
        ST_LIT_DATA,
        ST_LIT_SKIP,
        ST_RUN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SOLID,
        OP_SET_COUNT,
        OP_PAT_BYTE,
        OP_SET_REPEAT,
        OP_LIT_COUNT,
        OP_LIT_BYTE,
        OP_LIT_SKIP,
        OP_CHUNK
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic byte_zero;
        logic byte_literal;
        logic pat_done;
        logic lit_more;
        logic slot_free;
        logic run_last;
        logic line_full;
    } t_status;

endpackage

[src/bird_in_if.sv]
// ----------------------------------------------------------------------------
// bird_in_if: compressed byte channel
// Valid/ready channel carrying one byte of the compressed stream per item.
// ----------------------------------------------------------------------------
interface bird_in_if;
    logic                        valid;
    logic                        ready;
    logic [bird_pkg::CODE_W-1:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

[src/bird_out_if.sv]
// ----------------------------------------------------------------------------
// bird_out_if: decoded chunk channel
// Valid/ready channel carrying one chunk of decoded line bytes per item.
// ----------------------------------------------------------------------------
interface bird_out_if;
    logic                          valid;
    logic                          ready;
    logic [bird_pkg::CHUNK_W-1:0]  chunk_data;
    logic [bird_pkg::COUNT_W-1:0]  chunk_count;
    logic                          line_end;
    logic [bird_pkg::REPEAT_W-1:0] line_repeat;
    logic                          run_last;
    logic                          clipped;

    modport source (output valid, output chunk_data, output chunk_count,
                    output line_end, output line_repeat, output run_last,
                    output clipped, input ready);
    modport sink   (input valid, input chunk_data, input chunk_count,
                    input line_end, input line_repeat, input run_last,
                    input clipped, output ready);
endinterface

[src/bird_ctrl.sv]
// ----------------------------------------------------------------------------
// bird_ctrl: record parser and run sequencer
// Walks the record grammar of the compressed stream, decides when an input
// item is taken and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module bird_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bird_pkg::t_status i_status,
    output bird_pkg::t_cmd    o_cmd
);

    bird_pkg::t_state r_state;
    bird_pkg::t_state n_state;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bird_pkg::ST_OPCODE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = bird_pkg::OP_NONE;

        // A literal byte goes straight to the output register, so it waits
        // for a free slot; a run holds off input until its last chunk.
        unique case (r_state)
            bird_pkg::ST_RUN:      o_in_ready = 1'b0;
            bird_pkg::ST_LIT_DATA: o_in_ready = i_status.slot_free;
            default:               o_in_ready = 1'b1;
        endcase
        accept = i_in_valid && o_in_ready;

        unique case (r_state)
            bird_pkg::ST_OPCODE: begin
                if (accept) begin
                    if (i_status.byte_zero) begin
                        n_state = bird_pkg::ST_AFTER_ZERO;
                    end else if (i_status.byte_literal) begin
                        n_state = bird_pkg::ST_LIT_COUNT;
                    end else begin
                        o_cmd.op = bird_pkg::OP_SOLID;
                        n_state  = bird_pkg::ST_RUN;
                    end
                end
            end
            bird_pkg::ST_AFTER_ZERO: begin
                if (accept) begin
                    if (i_status.byte_zero) begin
                        n_state = bird_pkg::ST_SL_FLAG;
                    end else begin
                        o_cmd.op = bird_pkg::OP_SET_COUNT;
                        n_state  = bird_pkg::ST_PATTERN;
                    end
                end
            end
            bird_pkg::ST_PATTERN: begin
                if (accept) begin
                    o_cmd.op = bird_pkg::OP_PAT_BYTE;
                    if (i_status.pat_done) begin
                        n_state = bird_pkg::ST_RUN;
                    end
                end
            end
            bird_pkg::ST_SL_FLAG: begin
                if (accept) begin
                    n_state = bird_pkg::ST_SL_COUNT;
                end
            end
            bird_pkg::ST_SL_COUNT: begin
                if (accept) begin
                    o_cmd.op = bird_pkg::OP_SET_REPEAT;
                    n_state  = bird_pkg::ST_OPCODE;
                end
            end
            bird_pkg::ST_LIT_COUNT: begin
                if (accept) begin
                    o_cmd.op = bird_pkg::OP_LIT_COUNT;
                    n_state  = i_status.byte_zero ? bird_pkg::ST_OPCODE
                                                  : bird_pkg::ST_LIT_DATA;
                end
            end
            bird_pkg::ST_LIT_DATA: begin
                if (accept) begin
                    o_cmd.op = bird_pkg::OP_LIT_BYTE;
                    if (!i_status.lit_more) begin
                        n_state = bird_pkg::ST_OPCODE;
                    end else if (i_status.line_full) begin
                        // Line filled with literal bytes still pending.
                        n_state = bird_pkg::ST_LIT_SKIP;
                    end
                end
            end
            bird_pkg::ST_LIT_SKIP: begin
                if (accept) begin
                    o_cmd.op = bird_pkg::OP_LIT_SKIP;
                    if (!i_status.lit_more) begin
                        n_state = bird_pkg::ST_OPCODE;
                    end
                end
            end
            bird_pkg::ST_RUN: begin
                if (i_status.slot_free) begin
                    o_cmd.op = bird_pkg::OP_CHUNK;
                    if (i_status.run_last) begin
                        n_state = bird_pkg::ST_OPCODE;
                    end
                end
            end
            default: begin
                n_state = bird_pkg::ST_OPCODE;
            end
        endcase
    end

endmodule

[src/bird_dp.sv]
// ----------------------------------------------------------------------------
// bird_dp: decoder datapath
// Holds the configuration, pattern bytes, counters, line position and the
// run state, builds one output chunk per command and owns the output register.
// ----------------------------------------------------------------------------
module bird_dp #(
    parameter int MAX_LINE_BYTES    = 256,
    parameter int MAX_PATTERN_BYTES = 2,
    parameter int CHUNK_BYTES       = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bird_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bird_pkg::LINE_CFG_W-1:0]     i_cfg_data,
    input  logic [bird_pkg::CODE_W-1:0]         i_code_byte,
    input  bird_pkg::t_cmd                      i_cmd,
    output bird_pkg::t_status                   o_status,
    bird_out_if.source                          o_chunk
);

    localparam int LW = $clog2(MAX_LINE_BYTES + 1);
    localparam int CW = (LW > bird_pkg::TOTAL_W) ? LW : bird_pkg::TOTAL_W;

    // Configuration
    logic [bird_pkg::LINE_CFG_W-1:0] r_line_bytes;
    logic [bird_pkg::PLEN_W-1:0]     r_pattern_length;

    // Parser state
    logic [bird_pkg::CODE_W-1:0]     r_pat [MAX_PATTERN_BYTES];
    logic [bird_pkg::PLEN_W-1:0]     r_fill;
    logic [bird_pkg::CODE_W-1:0]     r_run_count;
    logic [bird_pkg::CODE_W-1:0]     r_lit_left;
    logic [LW-1:0]                   r_pos;
    logic [bird_pkg::REPEAT_W-1:0]   r_pending;

    // Run in progress
    logic [LW-1:0]                   r_take_left;
    logic                            r_hits_end;
    logic                            r_run_clip;
    logic [bird_pkg::CODE_W-1:0]     r_b0;
    logic [bird_pkg::CODE_W-1:0]     r_b1;
    logic                            r_phase;
    logic [bird_pkg::RES_W-1:0]      r_nres;

    // Output register
    logic                            r_out_valid;
    logic [bird_pkg::CHUNK_W-1:0]    r_data;
    logic [bird_pkg::COUNT_W-1:0]    r_count;
    logic                            r_line_end;
    logic [bird_pkg::REPEAT_W-1:0]   r_repeat;
    logic                            r_run_last;
    logic                            r_clipped;

    logic [CW-1:0]                   lim_w;
    logic [LW-1:0]                   lim;
    logic [bird_pkg::PLEN_W-1:0]     plen;
    logic [LW-1:0]                   rem;
    logic                            lit_le;
    logic [bird_pkg::CODE_W-1:0]     eff [MAX_PATTERN_BYTES];
    logic [bird_pkg::CODE_W-1:0]     pb0;
    logic [bird_pkg::CODE_W-1:0]     pb1;
    logic                            pat_done;
    logic [bird_pkg::CODE_W-1:0]     solid;
    logic [bird_pkg::TOTAL_W-1:0]    total;
    logic [CW-1:0]                   total_c;
    logic [CW-1:0]                   rem_c;
    logic [LW-1:0]                   take;
    logic                            slot_free;
    logic                            fin;
    logic                            cap;
    logic                            last;
    logic                            run_le;
    logic [bird_pkg::COUNT_W-1:0]    c4;
    logic [bird_pkg::CHUNK_W-1:0]    chunk;
    logic [bird_pkg::REPEAT_W-1:0]   rep_now;

    // Effective line width and pattern length.
    always_comb begin
        if (r_line_bytes == '0) begin
            lim_w = CW'(1);
        end else if (CW'(r_line_bytes) > CW'(MAX_LINE_BYTES)) begin
            lim_w = CW'(MAX_LINE_BYTES);
        end else begin
            lim_w = CW'(r_line_bytes);
        end
        lim = lim_w[LW-1:0];

        if (r_pattern_length == '0) begin
            plen = bird_pkg::PLEN_W'(1);
        end else if (r_pattern_length > bird_pkg::PLEN_W'(MAX_PATTERN_BYTES)) begin
            plen = bird_pkg::PLEN_W'(MAX_PATTERN_BYTES);
        end else begin
            plen = r_pattern_length;
        end
    end

    // A position at or past the line end leaves room for one byte only.
    assign rem    = (r_pos < lim) ? (lim - r_pos) : LW'(1);
    assign lit_le = (rem == LW'(1));

    // Pattern bytes with the byte being accepted bypassed into its slot.
    always_comb begin
        for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            eff[j] = (r_fill == bird_pkg::PLEN_W'(j)) ? i_code_byte : r_pat[j];
        end
        pb0 = eff[0];
        pb1 = (plen == bird_pkg::PLEN_W'(2)) ? eff[MAX_PATTERN_BYTES-1] : eff[0];
    end

    assign pat_done = ({1'b0, r_fill} + 3'd1) >= {1'b0, plen};
    assign solid    = i_code_byte[7] ? bird_pkg::SOLID_ONES : bird_pkg::BYTE_ZERO;

    // Run setup: bytes requested, clipped to the room left on the line.
    always_comb begin
        if (i_cmd.op == bird_pkg::OP_SOLID) begin
            total = bird_pkg::TOTAL_W'(i_code_byte & bird_pkg::MASK_COUNT);
        end else if (plen == bird_pkg::PLEN_W'(2)) begin
            total = {r_run_count, 1'b0};
        end else begin
            total = {1'b0, r_run_count};
        end
        total_c = CW'(total);
        rem_c   = CW'(rem);
        take    = (total_c < rem_c) ? total_c[LW-1:0] : rem;
    end

    // Chunk of the run in progress.
    assign slot_free = !r_out_valid || o_chunk.ready;
    assign fin       = r_take_left <= LW'(CHUNK_BYTES);
    assign cap       = r_nres == bird_pkg::RES_W'(bird_pkg::MAX_RESULTS - 1);
    assign last      = fin || cap;
    assign run_le    = fin && r_hits_end;
    assign c4        = fin ? r_take_left[bird_pkg::COUNT_W-1:0]
                           : bird_pkg::COUNT_W'(CHUNK_BYTES);

    always_comb begin
        chunk = '0;
        for (int i = 0; i < CHUNK_BYTES; i++) begin
            if (bird_pkg::COUNT_W'(i) < c4) begin
                chunk[8*i +: 8] = (((i % 2) != 0) ^ r_phase) ? r_b1 : r_b0;
            end
        end
    end

    always_comb begin
        rep_now = r_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes     <= bird_pkg::LINE_BYTES_RESET;
            r_pattern_length <= bird_pkg::PATTERN_LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bird_pkg::CFG_LINE_BYTES:     r_line_bytes     <= i_cfg_data;
                bird_pkg::CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[1:0];
                default:                      r_line_bytes     <= r_line_bytes;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bird_pkg::OP_PAT_BYTE) begin
            for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
                if (r_fill == bird_pkg::PLEN_W'(j)) begin
                    r_pat[j] <= i_code_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_run_count <= '0;
            r_lit_left  <= '0;
            r_pos       <= '0;
            r_pending   <= bird_pkg::REPEAT_W'(1);
            r_take_left <= '0;
            r_phase     <= 1'b0;
            r_nres      <= '0;
        end else begin
            unique case (i_cmd.op)
                bird_pkg::OP_SOLID: begin
                    r_take_left <= take;
                    r_phase     <= 1'b0;
                    r_nres      <= '0;
                end
                bird_pkg::OP_SET_COUNT: begin
                    r_run_count <= i_code_byte;
                    r_fill      <= '0;
                end
                bird_pkg::OP_PAT_BYTE: begin
                    if (pat_done) begin
                        r_fill      <= '0;
                        r_take_left <= take;
                        r_phase     <= 1'b0;
                        r_nres      <= '0;
                    end else begin
                        r_fill <= r_fill + bird_pkg::PLEN_W'(1);
                    end
                end
                bird_pkg::OP_SET_REPEAT: begin
                    // A repeat count of zero means the line appears once.
                    r_pending <= (i_code_byte == bird_pkg::BYTE_ZERO)
                                 ? bird_pkg::REPEAT_W'(1) : i_code_byte;
                end
                bird_pkg::OP_LIT_COUNT: begin
                    r_lit_left <= i_code_byte;
                end
                bird_pkg::OP_LIT_BYTE: begin
                    r_lit_left <= r_lit_left - 8'd1;
                    if (lit_le) begin
                        r_pos     <= '0;
                        r_pending <= bird_pkg::REPEAT_W'(1);
                    end else begin
                        r_pos <= r_pos + LW'(1);
                    end
                end
                bird_pkg::OP_LIT_SKIP: begin
                    r_lit_left <= r_lit_left - 8'd1;
                end
                bird_pkg::OP_CHUNK: begin
                    r_take_left <= r_take_left - LW'(c4);
                    r_phase     <= r_phase ^ c4[0];
                    r_nres      <= r_nres + bird_pkg::RES_W'(1);
                    if (run_le) begin
                        r_pos     <= '0;
                        r_pending <= bird_pkg::REPEAT_W'(1);
                    end else begin
                        r_pos <= r_pos + LW'(c4);
                    end
                end
                default: begin
                    r_fill <= r_fill;
                end
            endcase
        end
    end

    // Run payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bird_pkg::OP_SOLID) begin
            r_b0       <= solid;
            r_b1       <= solid;
            r_hits_end <= total_c >= rem_c;
            r_run_clip <= total_c > rem_c;
        end else if (i_cmd.op == bird_pkg::OP_PAT_BYTE && pat_done) begin
            r_b0       <= pb0;
            r_b1       <= pb1;
            r_hits_end <= total_c >= rem_c;
            r_run_clip <= total_c > rem_c;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == bird_pkg::OP_CHUNK || i_cmd.op == bird_pkg::OP_LIT_BYTE) begin
            r_out_valid <= 1'b1;
        end else if (o_chunk.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bird_pkg::OP_CHUNK) begin
            r_data     <= chunk;
            r_count    <= c4;
            r_line_end <= run_le;
            r_repeat   <= run_le ? rep_now : bird_pkg::REPEAT_W'(1);
            r_run_last <= last;
            // A chunk cut short by the result limit always drops bytes.
            r_clipped  <= last && (fin ? r_run_clip : 1'b1);
        end else if (i_cmd.op == bird_pkg::OP_LIT_BYTE) begin
            r_data     <= bird_pkg::CHUNK_W'(i_code_byte);
            r_count    <= bird_pkg::COUNT_W'(1);
            r_line_end <= lit_le;
            r_repeat   <= lit_le ? rep_now : bird_pkg::REPEAT_W'(1);
            r_run_last <= 1'b1;
            r_clipped  <= lit_le && (r_lit_left > 8'd1);
        end
    end

    assign o_chunk.valid       = r_out_valid;
    assign o_chunk.chunk_data  = r_data;
    assign o_chunk.chunk_count = r_count;
    assign o_chunk.line_end    = r_line_end;
    assign o_chunk.line_repeat = r_repeat;
    assign o_chunk.run_last    = r_run_last;
    assign o_chunk.clipped     = r_clipped;

    always_comb begin
        o_status.byte_zero    = i_code_byte == bird_pkg::BYTE_ZERO;
        o_status.byte_literal = i_code_byte == bird_pkg::BYTE_LITERAL;
        o_status.pat_done     = pat_done;
        o_status.lit_more     = r_lit_left > 8'd1;
        o_status.slot_free    = slot_free;
        o_status.run_last     = last;
        // Flags a literal byte that would end the line.
        o_status.line_full    = lit_le;
    end

endmodule

[src/bit_image_run_decoder_top.sv]
// ----------------------------------------------------------------------------
// bit_image_run_decoder_top: bitplane line decompressor
// Takes one compressed byte per input item on i_code and delivers decoded
// line bytes as chunks of up to CHUNK_BYTES on o_chunk, first byte lowest.
// Line width and pattern length are written through the i_cfg_* port while
// the block is idle; index 0 is the line width, index 1 the pattern length.
// Header, control and count bytes never wait for the output register and
// give no result. A literal data byte is taken once the output register is
// free and appears on o_chunk in the next cycle.
// A solid or pattern run is set up in the cycle its last byte is taken; the
// sequencer then writes one chunk per cycle into the output register while
// it is free, and holds off input until the run's last chunk is written.
// When o_chunk.ready is low a full output register holds its item and the
// sequencer waits; outside a run, bytes that give no result are still taken.
// Reset (i_rst_n low at a clock edge) returns the parser to the opcode state,
// clears the line position, sets the line repeat to one and loads the
// register defaults of 80 line bytes and a two-byte pattern.
// ----------------------------------------------------------------------------
module bit_image_run_decoder_top #(
    parameter int MAX_LINE_BYTES    = 256,
    parameter int MAX_PATTERN_BYTES = 2,
    parameter int CHUNK_BYTES       = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bird_in_if.sink                             i_code,
    bird_out_if.source                          o_chunk,
    input  logic                                i_cfg_we,
    input  logic [bird_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bird_pkg::LINE_CFG_W-1:0]     i_cfg_data
);

    bird_pkg::t_cmd    cmd;
    bird_pkg::t_status status;

    bird_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_code.valid),
        .o_in_ready (i_code.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bird_dp #(
        .MAX_LINE_BYTES    (MAX_LINE_BYTES),
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .CHUNK_BYTES       (CHUNK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_code_byte (i_code.code_byte),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_chunk     (o_chunk)
    );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: bit image run decoder
// Feeds solid runs, pattern runs, scanline runs and literal strings through
// the compressed byte channel under several line widths and pattern lengths.
// A scoreboard predicts the decoded chunks of every accepted byte and checks
// each chunk taken from the output channel. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import bird_pkg::*;

    localparam int LINE_CAP      = 256;
    localparam int PATTERN_CAP   = 2;
    localparam int CHUNK_CAP     = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 480;
    localparam int PRINT_LIMIT   = 100;

    class chunk_scoreboard;
        typedef struct packed {
            logic [CHUNK_W-1:0]  data;
            logic [COUNT_W-1:0]  count;
            logic                line_end;
            logic [REPEAT_W-1:0] line_rep;
            logic                run_end;
            logic                clip;
        } t_chunk;

        t_chunk                expected_chunks[$];
        int                    errors;
        t_state                phase;
        logic [CODE_W-1:0]     pat_bytes[PATTERN_CAP];
        int                    pat_fill;
        int                    run_len;
        int                    lit_left;
        int                    line_pos;
        logic [REPEAT_W-1:0]   line_rep;
        logic [LINE_CFG_W-1:0] line_cfg;
        logic [PLEN_W-1:0]     plen_cfg;

        function new();
            errors       = 0;
            phase        = ST_OPCODE;
            pat_bytes[0] = '0;
            pat_bytes[1] = '0;
            pat_fill     = 0;
            run_len      = 0;
            lit_left     = 0;
            line_pos     = 0;
            line_rep     = 8'd1;
            line_cfg     = LINE_BYTES_RESET;
            plen_cfg     = PATTERN_LENGTH_RESET;
        endfunction

        function void report(string what, logic [CHUNK_W-1:0] got, logic [CHUNK_W-1:0] want);
            if (errors < PRINT_LIMIT)
                $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $time);
            errors++;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [LINE_CFG_W-1:0] val);
            if (idx == CFG_LINE_BYTES)
                line_cfg = val;
            else
                plen_cfg = val[PLEN_W-1:0];
        endfunction

        // Out-of-range register values are folded into the legal range.
        function int line_limit();
            int v;
            v = int'(line_cfg);
            if (v == 0) v = 1;
            if (v > LINE_CAP) v = LINE_CAP;
            return v;
        endfunction

        function int pattern_len();
            int v;
            v = int'(plen_cfg);
            if (v == 0) v = 1;
            if (v > PATTERN_CAP) v = PATTERN_CAP;
            return v;
        endfunction

        // A position past a lowered line width leaves room for one byte.
        function int room();
            return (line_pos < line_limit()) ? line_limit() - line_pos : 1;
        endfunction

        function void push_chunk(logic [CHUNK_W-1:0] data, int count, logic closes,
                                 logic run_end, logic clip);
            t_chunk ch;
            ch.data     = data;
            ch.count    = COUNT_W'(count);
            ch.line_end = closes;
            ch.line_rep = closes ? line_rep : 8'd1;
            ch.run_end  = run_end;
            ch.clip     = clip;
            expected_chunks.push_back(ch);
        endfunction

        function void expand_run(logic [CODE_W-1:0] p0, logic [CODE_W-1:0] p1,
                                 int period, int total);
            int rem, take, k, n, c;
            logic [CHUNK_W-1:0] data;
            logic final_chunk;
            rem  = room();
            take = (total < rem) ? total : rem;
            k    = 0;
            n    = 0;
            while (k < take && n < MAX_RESULTS) begin
                c = take - k;
                if (c > CHUNK_CAP) c = CHUNK_CAP;
                data = '0;
                for (int i = 0; i < c; i++)
                    data[8*i +: 8] = (((k + i) % period) == 0) ? p0 : p1;
                k += c;
                n++;
                final_chunk = (k >= take) || (n == MAX_RESULTS);
                push_chunk(data, c, k == rem, final_chunk, final_chunk && (k < total));
            end
            if (k == rem) begin
                line_pos = 0;
                line_rep = 8'd1;
            end else begin
                line_pos += k;
            end
        endfunction

        function void decode_byte(logic [CODE_W-1:0] b);
            int p;
            logic closes;
            case (phase)
                ST_OPCODE: begin
                    if (b == BYTE_ZERO)
                        phase = ST_AFTER_ZERO;
                    else if (b == BYTE_LITERAL)
                        phase = ST_LIT_COUNT;
                    else if ((b & BYTE_LITERAL) != 0)
                        expand_run(SOLID_ONES, SOLID_ONES, 1, int'(b & MASK_COUNT));
                    else
                        expand_run(BYTE_ZERO, BYTE_ZERO, 1, int'(b & MASK_COUNT));
                end
                ST_AFTER_ZERO: begin
                    if (b == BYTE_ZERO) begin
                        phase = ST_SL_FLAG;
                    end else begin
                        run_len  = int'(b);
                        pat_fill = 0;
                        phase    = ST_PATTERN;
                    end
                end
                ST_PATTERN: begin
                    if (pat_fill < PATTERN_CAP) pat_bytes[pat_fill] = b;
                    pat_fill++;
                    if (pat_fill >= pattern_len()) begin
                        p        = pattern_len();
                        pat_fill = 0;
                        phase    = ST_OPCODE;
                        expand_run(pat_bytes[0], pat_bytes[1], p, run_len * p);
                    end
                end
                ST_SL_FLAG: phase = ST_SL_COUNT;
                ST_SL_COUNT: begin
                    line_rep = (b == BYTE_ZERO) ? 8'd1 : b;
                    phase    = ST_OPCODE;
                end
                ST_LIT_COUNT: begin
                    lit_left = int'(b);
                    phase    = (b == BYTE_ZERO) ? ST_OPCODE : ST_LIT_DATA;
                end
                ST_LIT_DATA: begin
                    closes = (room() == 1);
                    if (lit_left > 0) lit_left--;
                    push_chunk(CHUNK_W'(b), 1, closes, 1'b1, closes && lit_left > 0);
                    if (closes) begin
                        line_pos = 0;
                        line_rep = 8'd1;
                        phase    = (lit_left > 0) ? ST_LIT_SKIP : ST_OPCODE;
                    end else begin
                        line_pos++;
                        phase = (lit_left > 0) ? ST_LIT_DATA : ST_OPCODE;
                    end
                end
                default: begin
                    // Literal bytes past the line end are swallowed.
                    if (lit_left > 0) lit_left--;
                    if (lit_left == 0) phase = ST_OPCODE;
                end
            endcase
        endfunction

        function void check_chunk(logic [CHUNK_W-1:0] data, logic [COUNT_W-1:0] count,
                                  logic line_end, logic [REPEAT_W-1:0] rep,
                                  logic run_last, logic clipped);
            t_chunk want;
            if (expected_chunks.size() == 0) begin
                report("chunk with none expected, data", data, '0);
                return;
            end
            want = expected_chunks.pop_front();
            if (data !== want.data)         report("chunk_data", data, want.data);
            if (count !== want.count)       report("chunk_count", count, want.count);
            if (line_end !== want.line_end) report("line_end", line_end, want.line_end);
            if (rep !== want.line_rep)      report("line_repeat", rep, want.line_rep);
            if (run_last !== want.run_end)  report("run_last", run_last, want.run_end);
            if (clipped !== want.clip)      report("clipped", clipped, want.clip);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [LINE_CFG_W-1:0]  i_cfg_data;

    bird_in_if  code_if ();
    bird_out_if chunk_if ();

    chunk_scoreboard sb;
    int              items_sent;
    int              quiet_cycles;
    bit              no_gaps;

    logic [CODE_W-1:0] opening_bytes[$] = '{
        SOLID_ONES, MASK_COUNT,
        BYTE_ZERO, BYTE_ZERO, 8'h5A, BYTE_ZERO,
        BYTE_ZERO, 8'h05, 8'hAA, 8'h55,
        BYTE_ZERO, BYTE_ZERO, 8'hA5, 8'h03,
        BYTE_LITERAL, 8'h03, 8'h12, 8'h34, 8'hFE,
        BYTE_LITERAL, BYTE_ZERO,
        BYTE_ZERO, 8'hFF, 8'h0F, 8'hF0,
        BYTE_LITERAL | 8'h03
    };
    // Sent with a one-byte line while the position still sits past it.
    logic [CODE_W-1:0] short_line_bytes[$] = '{
        BYTE_LITERAL, 8'h02, 8'h11, 8'h22,
        BYTE_ZERO, 8'h03, 8'h77,
        BYTE_LITERAL | 8'h01, 8'h01
    };
    logic [LINE_CFG_W-1:0] line_plan[8] = '{9'd256, 9'd0, 9'd511, 9'd8,
                                            9'd37, 9'd255, 9'd3, 9'd100};
    logic [PLEN_W-1:0]     plen_plan[8] = '{2'd2, 2'd0, 2'd3, 2'd1,
                                            2'd2, 2'd1, 2'd2, 2'd3};

    bit_image_run_decoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_code      (code_if),
        .o_chunk     (chunk_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [CODE_W-1:0] b);
        int gap;
        gap = no_gaps ? 0 : idle_gap();
        if (gap > 0) begin
            code_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        code_if.valid     <= 1'b1;
        code_if.code_byte <= b;
        do @(posedge i_clk); while (code_if.ready !== 1'b1);
        sb.decode_byte(b);
        items_sent++;
    endtask

    // Mostly well-formed records with random content; a bit of raw noise.
    task automatic send_record();
        int kind, cnt;
        if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
        kind = $urandom_range(0, 99);
        if (sb.phase != ST_OPCODE || kind < 8) begin
            send_byte(CODE_W'($urandom_range(0, 255)));
        end else if (kind < 35) begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 16);
            if ($urandom_range(0, 1) == 1)
                send_byte(BYTE_LITERAL | (CODE_W'(cnt) & MASK_COUNT));
            else
                send_byte(CODE_W'(cnt) & MASK_COUNT);
        end else if (kind < 60) begin
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 10);
            send_byte(BYTE_ZERO);
            send_byte(CODE_W'(cnt));
            repeat (sb.pattern_len()) send_byte(CODE_W'($urandom_range(0, 255)));
        end else if (kind < 70) begin
            send_byte(BYTE_ZERO);
            send_byte(BYTE_ZERO);
            send_byte(CODE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                send_byte(BYTE_ZERO);
            else
                send_byte(CODE_W'($urandom_range(0, 255)));
        end else begin
            cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
            send_byte(BYTE_LITERAL);
            send_byte(CODE_W'(cnt));
            repeat (cnt) send_byte(CODE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [LINE_CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // Registers change only once the block has delivered everything and had
    // time to finish any byte that gives no result.
    task automatic drain_and_configure(input logic [LINE_CFG_W-1:0] line_val,
                                       input logic [PLEN_W-1:0] plen_val);
        code_if.valid <= 1'b0;
        while (sb.expected_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_LINE_BYTES, line_val);
        write_reg(CFG_PATTERN_LENGTH, {7'($urandom_range(0, 127)), plen_val});
        i_cfg_we <= 1'b0;
    endtask

    initial begin : sink_pacing
        int hold, gap;
        chunk_if.ready <= 1'b0;
        forever begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            @(posedge i_clk);
            chunk_if.ready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            gap = idle_gap();
            if (gap > 0) begin
                chunk_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && chunk_if.valid === 1'b1 && chunk_if.ready === 1'b1)
            sb.check_chunk(chunk_if.chunk_data, chunk_if.chunk_count, chunk_if.line_end,
                           chunk_if.line_repeat, chunk_if.run_last, chunk_if.clipped);
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (code_if.valid && code_if.ready) ||
            (chunk_if.valid && chunk_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int target;
        code_if.valid     <= 1'b0;
        code_if.code_byte <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_LINE_BYTES;
        i_cfg_data        <= '0;
        i_rst_n           <= 1'b0;
        quiet_cycles      = 0;
        items_sent        = 0;
        no_gaps           = 1'b0;
        sb                = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drain_and_configure(LINE_BYTES_RESET, PATTERN_LENGTH_RESET);
        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
        drain_and_configure(9'd1, 2'd1);
        foreach (short_line_bytes[i]) send_byte(short_line_bytes[i]);

        foreach (line_plan[i]) begin
            drain_and_configure(line_plan[i], plen_plan[i]);
            target = items_sent + RANDOM_ITEMS / 8;
            while (items_sent < target) send_record();
        end

        code_if.valid <= 1'b0;
        while (sb.expected_chunks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[sim.f]
src/bird_pkg.sv
src/bird_in_if.sv
src/bird_out_if.sv
src/bird_ctrl.sv
src/bird_dp.sv
src/bit_image_run_decoder_top.sv
test/testbench.sv
